### rtl/stt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stt_pkg;

  localparam int DEFAULT_DEPTH = 16;

  // first name character that makes an expiring timer post its message
  localparam logic [7:0] NAME_H = 8'h48;

  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_DONE   = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_ADD  = 2'd1,
    ACT_DEL  = 2'd2,
    ACT_SET  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EX,
    S_ADD,
    S_EMRD,
    S_EMLD,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [15:0] key;
    logic [7:0]  id;
    logic [15:0] param;
    logic [15:0] countdown;
  } entry_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] param;
  } expiry_t;

endpackage

`default_nettype wire

### rtl/stt_entry_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module stt_entry_ram
  import stt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH,
  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [IdxW-1:0] waddr,
  input  wire entry_t          wdata,
  input  wire logic            re,
  input  wire logic [IdxW-1:0] raddr_a,
  input  wire logic [IdxW-1:0] raddr_b,
  output entry_t               rdata_a,
  output entry_t               rdata_b
);

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

### rtl/software_timer_table.sv
`timescale 1ns / 1ps
`default_nettype none

// channel | handshake           | payload
// input   | in_valid / in_ready | action, name_key, msg_id, msg_param, timeout
// output  | out_valid/out_ready | kind, out_msg_id, out_msg_param, status,
//         |                     | entries_in_use, last
//
// add: from the accept it goes through S_ADD and S_FIN to its completion item.
// tick and delete: each slot examined passes S_RD and S_EX, each expiry item
// S_EMRD and S_EMLD; set goes on to S_ADD for its add. each examined slot costs
// a read of the entry ram and, on a tick or a key hit, a write back.
// expiry items are buffered during the walk and sent after it, so they carry
// the final entry count. rst clears the fsm, the entry count and out_valid.
// a new item is taken once the completion item sits in the output register.

module software_timer_table
  import stt_pkg::*;
#(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic [15:0] name_key,
  input  wire logic [7:0]  msg_id,
  input  wire logic [15:0] msg_param,
  input  wire logic [15:0] timeout,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             kind,
  output logic [7:0]       out_msg_id,
  output logic [15:0]      out_msg_param,
  output logic             status,
  output logic [4:0]       entries_in_use,
  output logic             last
);

  localparam int IdxW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CntW = $clog2(TABLE_DEPTH + 1);

  state_t state, state_next;

  logic [CntW-1:0] count;
  logic [CntW-1:0] idx;
  logic [CntW-1:0] nexp;
  logic [CntW-1:0] emit_idx;

  action_t     act;
  logic [15:0] key_r;
  logic [7:0]  id_r;
  logic [15:0] param_r;
  logic [15:0] tmo_r;
  logic        status_r;

  entry_t rd_a, rd_b;
  expiry_t rbuf [TABLE_DEPTH];
  expiry_t rbuf_q;

  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  entry_t          mem_wdata;
  logic            mem_re;
  logic [IdxW-1:0] last_slot;
  logic            in_range;
  logic            out_free;
  logic            expired;
  logic            post;
  logic            key_hit;
  logic            full;

  assign last_slot = IdxW'(count - CntW'(1));
  assign in_range  = idx < count;
  assign out_free  = !out_valid || out_ready;
  assign expired   = rd_a.countdown == 16'd0;
  assign post      = expired && (rd_a.key[15:8] == NAME_H);
  assign key_hit   = rd_a.key == key_r;
  assign full      = count >= CntW'(TABLE_DEPTH);

  stt_entry_ram #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .re     (mem_re),
    .raddr_a(idx[IdxW-1:0]),
    .raddr_b(last_slot),
    .rdata_a(rd_a),
    .rdata_b(rd_b)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (action_t'(action) == ACT_ADD) ? S_ADD : S_RD;
        end
      end
      S_RD: begin
        if (in_range) begin
          state_next = S_EX;
        end else if (act == ACT_TICK) begin
          state_next = (nexp != '0) ? S_EMRD : S_FIN;
        end else if (act == ACT_SET) begin
          state_next = S_ADD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_EX:   state_next = S_RD;
      S_ADD:  state_next = S_FIN;
      S_EMRD: state_next = S_EMLD;
      S_EMLD: begin
        if (out_free) begin
          state_next = (emit_idx + CntW'(1) == nexp) ? S_FIN : S_EMRD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ram control
  always_comb begin
    in_ready  = 1'b0;
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx[IdxW-1:0];
    mem_wdata = rd_b;
    case (state)
      S_IDLE: in_ready = 1'b1;
      S_RD:   mem_re = in_range;
      S_EX: begin
        if (act == ACT_TICK) begin
          mem_we = 1'b1;
          if (!expired) begin
            mem_wdata = rd_a;
            mem_wdata.countdown = rd_a.countdown - 16'd1;
          end
        end else begin
          // last live entry fills the hole; a self move rewrites the same data
          mem_we = key_hit;
        end
      end
      S_ADD: begin
        mem_we    = !full;
        mem_waddr = count[IdxW-1:0];
        mem_wdata = '{key: key_r, id: id_r, param: param_r, countdown: tmo_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (state == S_EX) begin
      if (act == ACT_TICK ? expired : key_hit) begin
        count <= count - CntW'(1);
      end
    end else if (state == S_ADD && !full) begin
      count <= count + CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          act      <= action_t'(action);
          key_r    <= name_key;
          id_r     <= msg_id;
          param_r  <= msg_param;
          tmo_r    <= timeout;
          status_r <= STATUS_OK;
          idx      <= '0;
          nexp     <= '0;
          emit_idx <= '0;
        end
      end
      S_EX: begin
        // a tick never looks at the moved entry again; a delete does
        if (act == ACT_TICK || !key_hit) begin
          idx <= idx + CntW'(1);
        end
        if (act == ACT_TICK && post) begin
          nexp <= nexp + CntW'(1);
        end
      end
      S_ADD: begin
        if (full) begin
          status_r <= STATUS_FULL;
        end
      end
      S_EMLD: begin
        if (out_free) begin
          emit_idx <= emit_idx + CntW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // expiry buffer, drained in slot order after the walk
  always_ff @(posedge clk) begin
    if (state == S_EX && act == ACT_TICK && post) begin
      rbuf[nexp[IdxW-1:0]] <= '{id: rd_a.id, param: rd_a.param};
    end
    if (state == S_EMRD) begin
      rbuf_q <= rbuf[emit_idx[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMLD || state == S_FIN) begin
      if (out_free) begin
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (state == S_EMLD) begin
        kind           <= KIND_EXPIRY;
        out_msg_id     <= rbuf_q.id;
        out_msg_param  <= rbuf_q.param;
        status         <= STATUS_OK;
        entries_in_use <= 5'(count);
        last           <= 1'b0;
      end else if (state == S_FIN) begin
        kind           <= KIND_DONE;
        out_msg_id     <= '0;
        out_msg_param  <= '0;
        status         <= status_r;
        entries_in_use <= 5'(count);
        last           <= 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && count != $past(count) |->
      (count == $past(count) + CntW'(1) || count == $past(count) - CntW'(1)))
    else $error("entry count moved by more than one");

  a_expiry_bound: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> nexp <= CntW'(TABLE_DEPTH))
    else $error("more expiries than table slots");

  a_last_is_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (kind == KIND_DONE)))
    else $error("last flag out of step with result kind");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state != S_IDLE && !in_ready)
    else $error("item accepted but fsm stayed idle");
`endif

endmodule

`default_nettype wire

### tb/software_timer_table_tb.sv
`timescale 1ns / 1ps

module software_timer_table_tb;
  import stt_pkg::*;

  localparam int DEPTH = DEFAULT_DEPTH;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int RANDOM_PHASES = 5;
  localparam int PHASE_ITEMS = 100;
  localparam int POOL_KEYS = 6;
  localparam logic [15:0] KEY_POOL [POOL_KEYS] = '{
    16'h4800, 16'h48FF, 16'h4841, 16'h0048, 16'hFFFF, 16'h1234
  };

  typedef struct packed {
    logic        kind;
    logic [7:0]  id;
    logic [15:0] param;
    logic        status;
    logic [4:0]  count;
    logic        last;
  } timer_result_t;

  typedef struct {
    action_t     act;
    logic [15:0] key;
    logic [7:0]  id;
    logic [15:0] prm;
    logic [15:0] tmo;
    int          reps;
    bit          pinned;
    logic        pin_status;
    logic [4:0]  pin_count;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = ACT_TICK;
  logic [15:0] name_key = '0;
  logic [7:0]  msg_id = '0;
  logic [15:0] msg_param = '0;
  logic [15:0] timeout = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        kind;
  logic [7:0]  out_msg_id;
  logic [15:0] out_msg_param;
  logic        status;
  logic [4:0]  entries_in_use;
  logic        last;

  // shadow copy of the timer table
  logic [15:0] t_key [DEPTH];
  logic [7:0]  t_id [DEPTH];
  logic [15:0] t_param [DEPTH];
  logic [15:0] t_cd [DEPTH];
  int unsigned t_live = 0;

  timer_result_t due_results [$];
  stim_row_t     plan [$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  software_timer_table #(.TABLE_DEPTH(DEPTH)) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .action(action),
    .name_key(name_key),
    .msg_id(msg_id),
    .msg_param(msg_param),
    .timeout(timeout),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .out_msg_id(out_msg_id),
    .out_msg_param(out_msg_param),
    .status(status),
    .entries_in_use(entries_in_use),
    .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void pull_last_into(int unsigned slot);
    int unsigned src;
    src = t_live - 1;
    if (slot != src) begin
      t_key[slot] = t_key[src];
      t_id[slot] = t_id[src];
      t_param[slot] = t_param[src];
      t_cd[slot] = t_cd[src];
    end
    t_live--;
  endfunction

  // moved entries are looked at again, so every match goes
  function automatic void drop_key(logic [15:0] k);
    int unsigned i;
    i = 0;
    while (i < t_live) begin
      if (t_key[i] == k) pull_last_into(i);
      else i++;
    end
  endfunction

  function automatic logic insert_timer(logic [15:0] k, logic [7:0] id, logic [15:0] prm,
                                        logic [15:0] tmo);
    if (t_live >= DEPTH) return STATUS_FULL;
    t_key[t_live] = k;
    t_id[t_live] = id;
    t_param[t_live] = prm;
    t_cd[t_live] = tmo;
    t_live++;
    return STATUS_OK;
  endfunction

  function automatic void run_timer_item(action_t act, logic [15:0] k, logic [7:0] id,
                                         logic [15:0] prm, logic [15:0] tmo);
    timer_result_t fired [$];
    timer_result_t r;
    logic st;
    int unsigned i;
    st = STATUS_OK;
    case (act)
      ACT_TICK: begin
        i = 0;
        while (i < t_live) begin
          if (t_cd[i] != 0) begin
            t_cd[i]--;
          end else begin
            if (t_key[i][15:8] == NAME_H) begin
              r = '{KIND_EXPIRY, t_id[i], t_param[i], STATUS_OK, 5'd0, 1'b0};
              fired.push_back(r);
            end
            // the entry moved in here waits for the next tick
            pull_last_into(i);
          end
          i++;
        end
      end
      ACT_ADD: st = insert_timer(k, id, prm, tmo);
      ACT_DEL: drop_key(k);
      default: begin
        drop_key(k);
        st = insert_timer(k, id, prm, tmo);
      end
    endcase
    r = '{KIND_DONE, 8'd0, 16'd0, st, 5'd0, 1'b1};
    fired.push_back(r);
    foreach (fired[j]) begin
      fired[j].count = t_live[4:0];
      due_results.push_back(fired[j]);
    end
  endfunction

  function automatic void note_mismatch(string what, timer_result_t want, timer_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: want kind=%0d id=%02h param=%04h st=%0d n=%0d last=%0d, got kind=%0d id=%02h param=%04h st=%0d n=%0d last=%0d",
               $realtime, what, want.kind, want.id, want.param, want.status, want.count,
               want.last, got.kind, got.id, got.param, got.status, got.count, got.last);
  endfunction

  // result checking and the stall watchdog
  always @(posedge clk) begin
    timer_result_t got;
    timer_result_t want;
    got = '{kind, out_msg_id, out_msg_param, status, entries_in_use, last};
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        note_mismatch("unexpected item", '0, got);
      end else begin
        want = due_results.pop_front();
        if (got !== want) note_mismatch("mismatch", want, got);
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic offer_item(action_t act, logic [15:0] k, logic [7:0] id, logic [15:0] prm,
                            logic [15:0] tmo);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    name_key <= k;
    msg_id <= id;
    msg_param <= prm;
    timeout <= tmo;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    run_timer_item(act, k, id, prm, tmo);
  endtask

  task automatic offer_random(int add_pct);
    action_t act;
    logic [15:0] k;
    logic [15:0] tmo;
    int r;
    r = $urandom_range(99);
    if (r < add_pct) act = ACT_ADD;
    else if (r < add_pct + 12) act = ACT_DEL;
    else if (r < add_pct + 24) act = ACT_SET;
    else act = ACT_TICK;
    if ($urandom_range(7) == 0) begin
      // stray keys only get short timers so they cannot clog the table
      k = 16'($urandom_range(16'hFFFF));
      tmo = 16'($urandom_range(6));
    end else begin
      k = KEY_POOL[$urandom_range(POOL_KEYS - 1)];
      r = $urandom_range(9);
      if (r < 7) tmo = 16'($urandom_range(4));
      else if (r < 9) tmo = 16'($urandom_range(20));
      else tmo = 16'($urandom_range(16'hFFFF));
    end
    offer_item(act, k, 8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)), tmo);
  endtask

  function automatic void plan_row(action_t act, logic [15:0] k, logic [7:0] id,
                                   logic [15:0] prm, logic [15:0] tmo, int reps,
                                   bit pinned, logic pst, logic [4:0] pcnt);
    stim_row_t row;
    row = '{act, k, id, prm, tmo, reps, pinned, pst, pcnt};
    plan.push_back(row);
  endfunction

  initial begin
    timer_result_t done_res;
    int add_pct;

    // act, key, id, param, timeout, reps, pinned, status, count
    plan_row(ACT_TICK, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1, 1, STATUS_OK, 5'd0);
    plan_row(ACT_DEL,  16'h4800, 8'h00, 16'h0000, 16'h0000, 1, 1, STATUS_OK, 5'd0);
    plan_row(ACT_ADD,  16'h4800, 8'hFF, 16'hFFFF, 16'h0000, 1, 1, STATUS_OK, 5'd1);
    plan_row(ACT_ADD,  16'hFFFF, 8'h00, 16'h0000, 16'hFFFF, 1, 1, STATUS_OK, 5'd2);
    plan_row(ACT_ADD,  16'h4841, 8'h12, 16'h5A5A, 16'h0001, 1, 1, STATUS_OK, 5'd3);
    plan_row(ACT_ADD,  16'h0000, 8'h34, 16'hA5A5, 16'h0000, 1, 1, STATUS_OK, 5'd4);
    // ticks ignore the payload fields
    plan_row(ACT_TICK, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1, 0, STATUS_OK, 5'd0);
    plan_row(ACT_TICK, 16'h4841, 8'h55, 16'h1234, 16'h0000, 1, 0, STATUS_OK, 5'd0);
    plan_row(ACT_SET,  16'h4841, 8'h56, 16'h1111, 16'h0002, 1, 1, STATUS_OK, 5'd2);
    plan_row(ACT_ADD,  16'h1234, 8'h78, 16'h2222, 16'h0000, 14, 0, STATUS_OK, 5'd0);
    // full table: drops, and set still deletes first
    plan_row(ACT_ADD,  16'h4877, 8'h9A, 16'h3333, 16'h0005, 1, 1, STATUS_FULL, 5'd16);
    plan_row(ACT_SET,  16'h7777, 8'hBC, 16'h4444, 16'h0005, 1, 1, STATUS_FULL, 5'd16);
    plan_row(ACT_SET,  16'h1234, 8'hDE, 16'h5555, 16'h0003, 1, 1, STATUS_OK, 5'd3);
    plan_row(ACT_DEL,  16'hFFFF, 8'hAA, 16'hAAAA, 16'hAAAA, 1, 1, STATUS_OK, 5'd2);
    plan_row(ACT_TICK, 16'h0000, 8'h00, 16'h0000, 16'h0000, 4, 0, STATUS_OK, 5'd0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[p]) begin
      for (int n = 0; n < plan[p].reps; n++) begin
        offer_item(plan[p].act, plan[p].key, plan[p].id, plan[p].prm, plan[p].tmo);
        if (plan[p].pinned) begin
          done_res = due_results.pop_back();
          done_res.status = plan[p].pin_status;
          done_res.count = plan[p].pin_count;
          due_results.push_back(done_res);
        end
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        1: begin send_idle_pct = 76; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 76; end
        3: begin send_idle_pct = 22; recv_stall_pct = 22; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      // back up the output while items keep coming
      if (ph == 0) hold_req++;
      add_pct = 40;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 25 == 0) add_pct = $urandom_range(20, 60);
        offer_random(add_pct);
      end
    end
    in_valid <= 1'b0;

    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
